>>> hdl/pvbe_pkg.sv
package pvbe_pkg;

  // command codes
  localparam logic [2:0] CMD_OPCODE    = 3'd0;
  localparam logic [2:0] CMD_UNSIGNED  = 3'd1;
  localparam logic [2:0] CMD_SIGNED    = 3'd2;
  localparam logic [2:0] CMD_TAG_UNS   = 3'd3;
  localparam logic [2:0] CMD_TAG_SIGN  = 3'd4;
  localparam logic [2:0] CMD_FLOAT32   = 3'd5;
  localparam logic [2:0] CMD_FLOAT64   = 3'd6;

  // configuration register indexes
  localparam logic [1:0] CFG_FLOAT_TAG  = 2'd0;
  localparam logic [1:0] CFG_DOUBLE_TAG = 2'd1;

  // lead byte prefixes
  localparam logic [7:0] LEAD_1  = 8'h80;
  localparam logic [7:0] LEAD_2  = 8'hC0;
  localparam logic [7:0] LEAD_3  = 8'hE0;
  localparam logic [7:0] LEAD_4  = 8'hF0;
  localparam logic [7:0] LEAD_5  = 8'hF8;
  localparam logic [7:0] LEAD_6  = 8'hFC;
  localparam logic [7:0] LEAD_7  = 8'hFE;
  localparam logic [7:0] LEAD_8  = 8'hFF;

  // exponent biases including the mantissa width
  localparam logic [12:0] BIAS_F32 = 13'd150;
  localparam logic [12:0] BIAS_F64 = 13'd1075;

  // one byte group: lead byte then rest bytes of data, high byte first
  typedef struct packed {
    logic [7:0]  lead;
    logic [3:0]  rest;
    logic [63:0] data;
  } grp_t;

  // one queued item: one or two groups
  typedef struct packed {
    grp_t g0;
    grp_t g1;
    logic has1;
  } entry_t;

  // zigzag mapping of a two's complement word
  function automatic logic [63:0] zigzag64(input logic [63:0] v);
    return {v[62:0], 1'b0} ^ {64{v[63]}};
  endfunction

  // prefix varint group of an unsigned word
  function automatic grp_t uvar_group(input logic [63:0] x);
    grp_t g;
    g.data = x;
    priority if (x[63:7] == '0) begin
      g.lead = x[7:0];
      g.rest = 4'd0;
    end else if (x[63:14] == '0) begin
      g.lead = LEAD_1 | {2'b00, x[13:8]};
      g.rest = 4'd1;
    end else if (x[63:21] == '0) begin
      g.lead = LEAD_2 | {3'b000, x[20:16]};
      g.rest = 4'd2;
    end else if (x[63:28] == '0) begin
      g.lead = LEAD_3 | {4'b0000, x[27:24]};
      g.rest = 4'd3;
    end else if (x[63:35] == '0) begin
      g.lead = LEAD_4 | {5'b00000, x[34:32]};
      g.rest = 4'd4;
    end else if (x[63:42] == '0) begin
      g.lead = LEAD_5 | {6'b000000, x[41:40]};
      g.rest = 4'd5;
    end else if (x[63:49] == '0) begin
      g.lead = LEAD_6 | {7'b0000000, x[48]};
      g.rest = 4'd6;
    end else if (x[63:56] == '0) begin
      g.lead = LEAD_7;
      g.rest = 4'd7;
    end else begin
      g.lead = LEAD_8;
      g.rest = 4'd8;
    end
    return g;
  endfunction

  // opcode group, wide opcodes keep only the low 32 bits
  function automatic grp_t op_group(input logic [63:0] x);
    grp_t g;
    g.data = x;
    priority if (x[63:8] == '0 && x[7:5] != 3'b111) begin
      g.lead = x[7:0];
      g.rest = 4'd0;
    end else if (x[63:12] == '0) begin
      g.lead = LEAD_3 | {4'b0000, x[11:8]};
      g.rest = 4'd1;
    end else if (x[63:19] == '0) begin
      g.lead = LEAD_4 | {5'b00000, x[18:16]};
      g.rest = 4'd2;
    end else if (x[63:26] == '0) begin
      g.lead = LEAD_5 | {6'b000000, x[25:24]};
      g.rest = 4'd3;
    end else begin
      g.lead = LEAD_6;
      g.rest = 4'd4;
    end
    return g;
  endfunction

endpackage

>>> hdl/pvbe_front.sv
module pvbe_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  logic [2:0]       command_i,
  input  logic [63:0]      value_i,
  input  logic [3:0]       tag_i,
  input  logic [3:0]       float_tag_i,
  input  logic [3:0]       double_tag_i,
  output logic             ent_valid_o,
  output pvbe_pkg::entry_t ent_o,
  input  logic             ent_ready_i
);
  import pvbe_pkg::*;

  logic        adv;
  logic        take;

  logic        s1_valid_q;
  logic [2:0]  s1_cmd_q;
  logic [63:0] s1_value_q;
  logic [3:0]  s1_tag_q;

  logic        s2_valid_q;
  logic [2:0]  s2_cmd_q;
  logic [63:0] s2_value_q;
  logic [3:0]  s2_tag_q;
  logic [52:0] s2_msh_q;
  logic [11:0] s2_ebase_q;
  logic        s2_is64_q;
  logic        s2_neg_q;

  logic        s3_valid_q;
  logic        s3_drop_q;
  logic        s3_op_q;
  logic        s3_has1_q;
  logic [63:0] s3_x0_q;
  logic [53:0] s3_x1_q;

  logic [3:0]  tag_sel;
  logic        is64;
  logic [52:0] mant;
  logic [10:0] expf;
  logic [55:0] mant56;
  logic [2:0]  kb;
  logic [52:0] msh;
  logic [11:0] ebase;

  logic [2:0]  jb;
  logic [52:0] m2;
  logic [12:0] e13;
  logic [13:0] zz14;
  logic [63:0] zzv;
  logic        drop_d;
  logic        op_d;
  logic        has1_d;
  logic [63:0] x0_d;
  logic [53:0] x1_d;

  // whole front moves together, stalls only when the queue is full
  assign adv         = !s3_valid_q || s3_drop_q || ent_ready_i;
  assign req_ready_o = adv;
  assign take        = req_valid_i && adv;

  // float modes take their tag from configuration
  always_comb begin
    if (command_i == CMD_FLOAT32) begin
      tag_sel = float_tag_i;
    end else if (command_i == CMD_FLOAT64) begin
      tag_sel = double_tag_i;
    end else begin
      tag_sel = tag_i;
    end
  end

  // stage one: mantissa split and trailing zero bytes
  always_comb begin
    is64 = (s1_cmd_q == CMD_FLOAT64);
    if (is64) begin
      mant = {1'b1, s1_value_q[51:0]};
      expf = s1_value_q[62:52];
    end else begin
      mant = {29'd0, 1'b1, s1_value_q[22:0]};
      expf = {3'b000, s1_value_q[30:23]};
    end
    mant56 = {3'b000, mant};
    kb = '0;
    for (int i = 6; i >= 0; i--) begin
      if (mant56[8*i +: 8] != 8'h00) kb = 3'(i);
    end
    msh   = mant >> {kb, 3'b000};
    ebase = {1'b0, expf} + {6'd0, kb, 3'b000};
  end

  // stage two: trailing zero bits, exponent and operand words
  always_comb begin
    jb = '0;
    for (int i = 7; i >= 0; i--) begin
      if (s2_msh_q[i]) jb = 3'(i);
    end
    m2   = s2_msh_q >> jb;
    e13  = {1'b0, s2_ebase_q} + {10'd0, jb} - (s2_is64_q ? BIAS_F64 : BIAS_F32);
    zz14 = {e13, 1'b0} ^ {14{e13[12]}};
    zzv  = zigzag64(s2_value_q);
    drop_d = 1'b0;
    op_d   = 1'b0;
    has1_d = 1'b0;
    x0_d   = s2_value_q;
    x1_d   = {m2, 1'b0} - {53'd0, s2_neg_q};
    unique case (s2_cmd_q)
      CMD_OPCODE:   op_d = 1'b1;
      CMD_UNSIGNED: x0_d = s2_value_q;
      CMD_SIGNED:   x0_d = zzv;
      CMD_TAG_UNS:  x0_d = {s2_value_q[59:0], s2_tag_q};
      CMD_TAG_SIGN: x0_d = {zzv[59:0], s2_tag_q};
      CMD_FLOAT32, CMD_FLOAT64: begin
        x0_d   = {46'd0, zz14, s2_tag_q};
        has1_d = 1'b1;
      end
      default:      drop_d = 1'b1;
    endcase
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s3_drop_q  <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= take;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s3_drop_q  <= drop_d;
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_cmd_q   <= command_i;
      s1_value_q <= value_i;
      s1_tag_q   <= tag_sel;
      s2_cmd_q   <= s1_cmd_q;
      s2_value_q <= s1_value_q;
      s2_tag_q   <= s1_tag_q;
      s2_msh_q   <= msh;
      s2_ebase_q <= ebase;
      s2_is64_q  <= is64;
      s2_neg_q   <= is64 ? s1_value_q[63] : s1_value_q[31];
      s3_op_q    <= op_d;
      s3_has1_q  <= has1_d;
      s3_x0_q    <= x0_d;
      s3_x1_q    <= x1_d;
    end
  end

  // group classification into the queue entry
  always_comb begin
    ent_o.g0   = s3_op_q ? op_group(s3_x0_q) : uvar_group(s3_x0_q);
    ent_o.g1   = uvar_group({10'd0, s3_x1_q});
    ent_o.has1 = s3_has1_q;
  end

  assign ent_valid_o = s3_valid_q && !s3_drop_q;

endmodule

>>> hdl/pvbe_fifo.sv
module pvbe_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  pvbe_pkg::entry_t wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output pvbe_pkg::entry_t rdata_o,
  output logic             empty_o
);
  import pvbe_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  entry_t          mem_q [DEPTH];
  logic [AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

>>> hdl/pvbe_back.sv
module pvbe_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             ent_valid_i,
  input  pvbe_pkg::entry_t ent_i,
  output logic             ent_pop_o,
  output logic             out_valid_o,
  input  logic             out_pop_i,
  output logic [7:0]       out_byte_o,
  output logic             last_o
);
  import pvbe_pkg::*;

  entry_t      ent_q;
  logic        busy_q, busy_d;
  logic        grp_q, grp_d;
  logic        at_lead_q, at_lead_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q;
  logic        out_last_q;

  grp_t        cur;
  logic        final_grp;
  logic        grp_end;
  logic        step;
  logic        finish;
  logic [7:0]  byte_val;
  logic [3:0]  rest_m1;

  // current group and the byte it sends next
  assign cur       = grp_q ? ent_q.g1 : ent_q.g0;
  assign final_grp = grp_q || !ent_q.has1;
  assign grp_end   = at_lead_q ? (cur.rest == 4'd0) : (cnt_q == 3'd0);
  assign byte_val  = at_lead_q ? cur.lead : cur.data[{cnt_q, 3'b000} +: 8];
  assign rest_m1   = cur.rest - 4'd1;

  // a byte moves when the output register is free or being drained
  assign step      = busy_q && (!out_valid_q || out_pop_i);
  assign finish    = step && grp_end && final_grp;
  assign ent_pop_o = ent_valid_i && (!busy_q || finish);

  // byte sequencer
  always_comb begin
    busy_d    = busy_q;
    grp_d     = grp_q;
    at_lead_d = at_lead_q;
    cnt_d     = cnt_q;
    if (ent_pop_o) begin
      busy_d    = 1'b1;
      grp_d     = 1'b0;
      at_lead_d = 1'b1;
    end else if (finish) begin
      busy_d = 1'b0;
    end else if (step) begin
      if (grp_end) begin
        grp_d     = 1'b1;
        at_lead_d = 1'b1;
      end else if (at_lead_q) begin
        at_lead_d = 1'b0;
        cnt_d     = rest_m1[2:0];
      end else begin
        cnt_d = cnt_q - 3'd1;
      end
    end
  end

  // output register
  always_comb begin
    if (step) begin
      out_valid_d = 1'b1;
    end else if (out_pop_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      grp_q       <= 1'b0;
      at_lead_q   <= 1'b1;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      grp_q       <= grp_d;
      at_lead_q   <= at_lead_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ent_pop_o) begin
      ent_q <= ent_i;
    end
    if (step) begin
      out_byte_q <= byte_val;
      out_last_q <= grp_end && final_grp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = out_last_q;

endmodule

>>> hdl/prefix_varint_bytecode_encoder.sv
// Variable-length byte encoder for opcodes, integers and float constants.
// Input side is a queue: drive command_i, value_i and tag_i and raise push;
// the request is taken on a clock edge where push is high and full is low.
// Output side is a queue too: while empty is low, out_byte_o and last_o show
// the oldest byte; raise pop to take it. last_o marks the final byte of a
// request. Command 7 produces no bytes.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
// index 0 is the float32 exponent tag, index 1 the float64 exponent tag.
// The first byte of a request passes the three front stages, the request
// queue, the byte sequencer register and the output register.
// Throughput: the byte sequencer sends one byte per cycle while pop keeps
// the output register free, for requests of 1 to 11 bytes; the front takes a
// request every cycle while the queue between front and sequencer has room.
// Reset clears all queues and sets both tags to zero; empty is high.
// When pop stays low the output byte holds, the sequencer stops, the queue
// fills and then full rises until bytes are taken again.
module prefix_varint_bytecode_encoder #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  command_i,
  input  logic [63:0] value_i,
  input  logic [3:0]  tag_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [3:0]  cfg_data_i
);
  import pvbe_pkg::*;

  logic [3:0] float_tag_q;
  logic [3:0] double_tag_q;

  logic       front_ready;
  logic       ent_valid;
  entry_t     ent_front;
  entry_t     ent_fifo;
  logic       fifo_push;
  logic       fifo_full;
  logic       fifo_empty;
  logic       fifo_pop;
  logic       out_valid;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      float_tag_q  <= '0;
      double_tag_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FLOAT_TAG:  float_tag_q  <= cfg_data_i;
        CFG_DOUBLE_TAG: double_tag_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front: accept and classify
  pvbe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (push),
    .req_ready_o  (front_ready),
    .command_i    (command_i),
    .value_i      (value_i),
    .tag_i        (tag_i),
    .float_tag_i  (float_tag_q),
    .double_tag_i (double_tag_q),
    .ent_valid_o  (ent_valid),
    .ent_o        (ent_front),
    .ent_ready_i  (!fifo_full)
  );

  assign full      = !front_ready;
  assign fifo_push = ent_valid && !fifo_full;

  // request queue between front and sequencer
  pvbe_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .wdata_i (ent_front),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .rdata_o (ent_fifo),
    .empty_o (fifo_empty)
  );

  // back: byte sequencer and output register
  pvbe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ent_valid_i (!fifo_empty),
    .ent_i       (ent_fifo),
    .ent_pop_o   (fifo_pop),
    .out_valid_o (out_valid),
    .out_pop_i   (pop),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o)
  );

  assign empty = !out_valid;

  // queue never written when full
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_push |-> !fifo_full)
    else $error("request queue written while full");

  // sequencer only loads from a filled queue
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_pop |-> !fifo_empty)
    else $error("request queue read while empty");

  // input stalls only because the queue is full
  a_full_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> fifo_full)
    else $error("input stalled without a full queue");

endmodule

>>> tb/tb_prefix_varint_bytecode_encoder.sv
module tb_prefix_varint_bytecode_encoder;
  import pvbe_pkg::*;

  // command code with no encoding
  localparam logic [2:0] CMD_UNUSED = 3'd7;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [2:0]  command_i;
  logic [63:0] value_i;
  logic [3:0]  tag_i;
  logic        empty;
  logic        pop;
  logic [7:0]  out_byte_o;
  logic        last_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [3:0]  cfg_data_i;

  // one request; known rows carry their byte string, right-aligned
  typedef struct packed {
    logic [2:0]  cmd;
    logic [63:0] value;
    logic [3:0]  tag;
    logic        known;
    logic [3:0]  n;
    logic [87:0] bytes;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } enc_byte_t;

  enc_byte_t expected_bytes[$];
  stim_row_t directed_rows[$];
  logic [3:0] float_tag_q;
  logic [3:0] double_tag_q;
  int mismatch_count;
  logic send_calm;
  logic recv_calm;

  prefix_varint_bytecode_encoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .command_i   (command_i),
    .value_i     (value_i),
    .tag_i       (tag_i),
    .empty       (empty),
    .pop         (pop),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // encoding predictor
  function automatic logic [63:0] zigzag_map(input logic [63:0] x);
    return (x << 1) ^ {64{x[63]}};
  endfunction

  function automatic void emit_group(input logic [7:0] lead, input logic [63:0] x,
                                     input int rest);
    expected_bytes.push_back('{data: lead, last: 1'b0});
    for (int k = rest - 1; k >= 0; k--) begin
      expected_bytes.push_back('{data: 8'(x >> (8 * k)), last: 1'b0});
    end
  endfunction

  function automatic void emit_varint(input logic [63:0] x);
    if (x < 64'h80)                     emit_group(x[7:0], x, 0);
    else if (x < 64'h4000)              emit_group(8'h80 | x[15:8], x, 1);
    else if (x < 64'h20_0000)           emit_group(8'hC0 | x[23:16], x, 2);
    else if (x < 64'h1000_0000)         emit_group(8'hE0 | x[31:24], x, 3);
    else if (x < 64'h8_0000_0000)       emit_group(8'hF0 | x[39:32], x, 4);
    else if (x < 64'h400_0000_0000)     emit_group(8'hF8 | x[47:40], x, 5);
    else if (x < 64'h2_0000_0000_0000)  emit_group(8'hFC | x[55:48], x, 6);
    else if (x < 64'h100_0000_0000_0000) emit_group(8'hFE, x, 7);
    else                                emit_group(8'hFF, x, 8);
  endfunction

  function automatic void emit_opcode(input logic [63:0] x);
    if (x < 64'hE0)             emit_group(x[7:0], x, 0);
    else if (x < 64'h1000)      emit_group(8'hE0 | x[15:8], x, 1);
    else if (x < 64'h8_0000)    emit_group(8'hF0 | x[23:16], x, 2);
    else if (x < 64'h400_0000)  emit_group(8'hF8 | x[31:24], x, 3);
    else                        emit_group(8'hFC, x, 4);
  endfunction

  // exponent then mantissa, trailing zeros of the mantissa folded into the exponent
  function automatic void emit_float(input logic [63:0] mant, input logic [63:0] expf,
                                     input logic [63:0] bias, input logic neg,
                                     input logic [3:0] ftag);
    logic [63:0] m;
    logic [63:0] e;
    m = mant;
    e = expf - bias;
    while (m[7:0] == 8'd0) begin
      m = m >> 8;
      e = e + 64'd8;
    end
    while (m[0] == 1'b0) begin
      m = m >> 1;
      e = e + 64'd1;
    end
    emit_varint((zigzag_map(e) << 4) | {60'd0, ftag});
    if (neg) m = -m;
    emit_varint(zigzag_map(m));
  endfunction

  function automatic void predict_encoding(input stim_row_t r);
    int first;
    enc_byte_t tail;
    first = expected_bytes.size();
    if (r.known) begin
      for (int i = 0; i < int'(r.n); i++) begin
        expected_bytes.push_back('{data: r.bytes[8 * (int'(r.n) - 1 - i) +: 8], last: 1'b0});
      end
    end else begin
      case (r.cmd)
        CMD_OPCODE:   emit_opcode(r.value);
        CMD_UNSIGNED: emit_varint(r.value);
        CMD_SIGNED:   emit_varint(zigzag_map(r.value));
        CMD_TAG_UNS:  emit_varint((r.value << 4) | {60'd0, r.tag});
        CMD_TAG_SIGN: emit_varint((zigzag_map(r.value) << 4) | {60'd0, r.tag});
        CMD_FLOAT32:  emit_float({40'd0, 1'b1, r.value[22:0]}, {56'd0, r.value[30:23]},
                                 64'(BIAS_F32), r.value[31], float_tag_q);
        CMD_FLOAT64:  emit_float({11'd0, 1'b1, r.value[51:0]}, {53'd0, r.value[62:52]},
                                 64'(BIAS_F64), r.value[63], double_tag_q);
        default: ;
      endcase
    end
    if (expected_bytes.size() > first) begin
      tail = expected_bytes.pop_back();
      tail.last = 1'b1;
      expected_bytes.push_back(tail);
    end
  endfunction

  // idle cycles before the next request or pop, with stretches of none
  function automatic int draw_wait(inout logic calm);
    if ($urandom_range(0, 19) == 0) calm = !calm;
    return calm ? 0 : int'($urandom_range(0, 17));
  endfunction

  function automatic void add_row(input logic [2:0] cmd, input logic [63:0] value,
                                  input logic [3:0] tag, input logic known,
                                  input logic [3:0] n, input logic [87:0] bytes);
    directed_rows.push_back('{cmd: cmd, value: value, tag: tag, known: known,
                              n: n, bytes: bytes});
  endfunction

  function automatic stim_row_t random_row();
    stim_row_t r;
    int w;
    int pick;
    pick = $urandom_range(0, 31);
    r.cmd = (pick == 0) ? CMD_UNUSED : 3'(pick % 7);
    r.value = {$urandom, $urandom};
    r.tag = 4'($urandom_range(0, 15));
    r.known = 1'b0;
    r.n = 4'd0;
    r.bytes = '0;
    if (r.cmd == CMD_FLOAT32 || r.cmd == CMD_FLOAT64) begin
      // clear low mantissa bits so the zero stripping runs to various depths
      w = $urandom_range(0, (r.cmd == CMD_FLOAT32) ? 24 : 53);
      r.value = r.value & ~((64'd1 << w) - 64'd1);
    end else begin
      // random magnitude so every length class turns up
      w = $urandom_range(0, 64);
      if (w < 64) r.value = r.value & ((64'd1 << w) - 64'd1);
      if ($urandom_range(0, 3) == 0) r.value = ~r.value;
    end
    return r;
  endfunction

  // request side
  task automatic send_item(input stim_row_t r);
    int gap;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push      <= 1'b1;
    command_i <= r.cmd;
    value_i   <= r.value;
    tag_i     <= r.tag;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_encoding(r);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [3:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (index == CFG_FLOAT_TAG) float_tag_q = data;
    else if (index == CFG_DOUBLE_TAG) double_tag_q = data;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // let every expected byte out, then cover the pipeline latency
  task automatic drain();
    push <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  // result side and checking
  initial begin
    int gap;
    enc_byte_t want;
    pop <= 1'b0;
    recv_calm = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      gap = draw_wait(recv_calm);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected byte, expected none, got %02h last %0b",
                 $time, out_byte_o, last_o);
        mismatch_count++;
      end else begin
        want = expected_bytes.pop_front();
        if (out_byte_o !== want.data) begin
          $display("%0t: byte mismatch, expected %02h, got %02h",
                   $time, want.data, out_byte_o);
          mismatch_count++;
        end
        if (last_o !== want.last) begin
          $display("%0t: last mismatch, expected %0b, got %0b",
                   $time, want.last, last_o);
          mismatch_count++;
        end
      end
    end
  end

  // main sequence
  initial begin
    logic [3:0] ftag;
    logic [3:0] dtag;
    rst_ni      <= 1'b0;
    push        <= 1'b0;
    command_i   <= '0;
    value_i     <= '0;
    tag_i       <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    float_tag_q  = 4'd0;
    double_tag_q = 4'd0;
    mismatch_count = 0;
    send_calm = 1'b0;

    // directed requests: length boundaries, wide opcode, tag overflow, odd floats
    add_row(CMD_OPCODE,   64'h0,                  4'h0, 1'b1, 4'd1, 88'h00);
    add_row(CMD_OPCODE,   64'hDF,                 4'h0, 1'b1, 4'd1, 88'hDF);
    add_row(CMD_OPCODE,   64'hE0,                 4'h0, 1'b1, 4'd2, 88'hE0E0);
    add_row(CMD_OPCODE,   64'hFFF,                4'h0, 1'b1, 4'd2, 88'hEFFF);
    add_row(CMD_OPCODE,   64'h1000,               4'h0, 1'b1, 4'd3, 88'hF01000);
    add_row(CMD_OPCODE,   64'h7FFFF,              4'h0, 1'b0, 4'd0, '0);
    add_row(CMD_OPCODE,   64'h3FFFFFF,            4'h0, 1'b0, 4'd0, '0);
    add_row(CMD_OPCODE,   64'h4000000,            4'h0, 1'b1, 4'd5, 88'hFC04000000);
    add_row(CMD_OPCODE,   '1,                     4'hF, 1'b1, 4'd5, 88'hFCFFFFFFFF);
    add_row(CMD_UNSIGNED, 64'h0,                  4'h0, 1'b1, 4'd1, 88'h00);
    add_row(CMD_UNSIGNED, 64'h7F,                 4'h0, 1'b1, 4'd1, 88'h7F);
    add_row(CMD_UNSIGNED, 64'h80,                 4'h0, 1'b1, 4'd2, 88'h8080);
    add_row(CMD_UNSIGNED, 64'h00FF_FFFF_FFFF_FFFF, 4'h0, 1'b1, 4'd8, 88'hFEFFFFFFFFFFFFFF);
    add_row(CMD_UNSIGNED, '1,                     4'h0, 1'b1, 4'd9, 88'hFFFFFFFFFFFFFFFFFF);
    add_row(CMD_SIGNED,   '1,                     4'h0, 1'b1, 4'd1, 88'h01);
    add_row(CMD_SIGNED,   64'h8000_0000_0000_0000, 4'h0, 1'b1, 4'd9, 88'hFFFFFFFFFFFFFFFFFF);
    add_row(CMD_SIGNED,   64'h7FFF_FFFF_FFFF_FFFF, 4'h0, 1'b0, 4'd0, '0);
    add_row(CMD_TAG_UNS,  64'hF000_0000_0000_0000, 4'hF, 1'b1, 4'd1, 88'h0F);
    add_row(CMD_TAG_SIGN, '1,                     4'h0, 1'b1, 4'd1, 88'h10);
    add_row(CMD_FLOAT32,  64'hFFFF_FFFF_3F80_0000, 4'h0, 1'b0, 4'd0, '0);
    add_row(CMD_FLOAT32,  64'h0,                  4'h0, 1'b0, 4'd0, '0);
    add_row(CMD_FLOAT32,  64'hFFFF_FFFF,          4'h0, 1'b0, 4'd0, '0);
    add_row(CMD_FLOAT64,  64'h0,                  4'h0, 1'b0, 4'd0, '0);
    add_row(CMD_FLOAT64,  '1,                     4'h0, 1'b0, 4'd0, '0);
    add_row(CMD_UNUSED,   '1,                     4'hF, 1'b1, 4'd0, '0);

    // reset
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) send_item(directed_rows[i]);
    drain();

    // random phases, each under its own tag setting
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin ftag = 4'hF; dtag = 4'h0; end
        1: begin ftag = 4'h0; dtag = 4'hF; end
        2: begin ftag = 4'($urandom_range(0, 15)); dtag = 4'($urandom_range(0, 15)); end
        default: begin ftag = 4'hF; dtag = 4'hF; end
      endcase
      write_reg(CFG_FLOAT_TAG, ftag);
      write_reg(CFG_DOUBLE_TAG, dtag);
      for (int i = 0; i < 61; i++) send_item(random_row());
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && expected_bytes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
